// ===== hw/rtl/tlru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlru_pkg;

  // recency list end registers
  localparam logic [1:0] ACT_HEAD = 2'd0;
  localparam logic [1:0] ACT_TAIL = 2'd1;
  localparam logic [1:0] INA_HEAD = 2'd2;
  localparam logic [1:0] INA_TAIL = 2'd3;

  // golden ratio hash multiplier, split into halves
  localparam logic [31:0] HASH_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_HI = 32'h9E3779B9;

  // one result word
  typedef struct packed {
    logic        hit;
    logic [11:0] slot;
    logic        filled;
    logic        evicted;
    logic [7:0]  evicted_device;
    logic [31:0] evicted_page;
    logic [11:0] demoted;
    logic [12:0] pages_used;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
  } tlru_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlru_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// access request channel
interface tlru_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  device;
  logic [31:0] page_number;
  modport source (output valid, cmd, device, page_number, input ready);
  modport sink (input valid, cmd, device, page_number, output ready);
endinterface

// result channel
interface tlru_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [11:0] slot;
  logic        filled;
  logic        evicted;
  logic [7:0]  evicted_device;
  logic [31:0] evicted_page;
  logic [11:0] demoted;
  logic [12:0] pages_used;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] evict_count;
  modport source (output valid, hit, slot, filled, evicted, evicted_device, evicted_page,
                  demoted, pages_used, hit_count, miss_count, evict_count, input ready);
  modport sink (input valid, hit, slot, filled, evicted, evicted_device, evicted_page,
                demoted, pages_used, hit_count, miss_count, evict_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tlru_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlru_hash #(
  parameter int BUCKETS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bkt
);
  import tlru_pkg::*;

  localparam int          BI    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit          POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));
  localparam logic [31:0] BDIV  = 32'(BUCKETS);

  typedef enum logic [3:0] {
    H_IDLE, H_M0, H_M1, H_M2, H_M3, H_Q0, H_Q1, H_Q2, H_DONE
  } hstate_t;

  hstate_t       state;
  logic [63:0]   xr;
  logic [31:0]   ma, mb;
  logic [63:0]   p;
  logic [31:0]   acc;
  logic [BI-1:0] r;
  logic [31:0]   diff, dsub;

  // operand select for the shared multiplier
  always_comb begin
    ma = xr[31:0];
    mb = HASH_LO;
    case (state)
      H_M1: begin
        ma = xr[31:0];
        mb = HASH_HI;
      end
      H_M2: begin
        ma = xr[63:32];
        mb = HASH_LO;
      end
      // quotient estimate, then quotient times bucket count
      H_Q0: begin
        ma = acc;
        mb = RECIP;
      end
      H_Q1: begin
        ma = p[63:32];
        mb = BDIV;
      end
      default: begin
        ma = xr[31:0];
        mb = HASH_LO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  assign diff = acc - p[31:0];
  assign dsub = diff - BDIV;
  assign done = (state == H_DONE);
  assign bkt  = POW2 ? BI'(acc & 32'(BUCKETS - 1)) : r;

  // upper product word, then remainder by reciprocal and one correction when BUCKETS is not a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (start) begin
            xr    <= x;
            state <= H_M0;
          end
        end
        H_M0: state <= H_M1;
        H_M1: begin
          acc   <= p[63:32];
          state <= H_M2;
        end
        H_M2: begin
          acc   <= acc + p[31:0];
          state <= H_M3;
        end
        H_M3: begin
          acc   <= acc + p[31:0];
          state <= POW2 ? H_DONE : H_Q0;
        end
        H_Q0: state <= H_Q1;
        H_Q1: state <= H_Q2;
        H_Q2: begin
          r     <= (diff >= BDIV) ? BI'(dsub) : BI'(diff);
          state <= H_DONE;
        end
        H_DONE: state <= H_IDLE;
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tlru_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlru_engine #(
  parameter int ENTRIES     = 4096,
  parameter int BUCKETS     = 1024,
  parameter int DEVICE_BITS = 8,
  parameter int PAGE_BITS   = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  tlru_req_if.sink            req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output tlru_pkg::tlru_res_t res
);
  import tlru_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int BI = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(BUCKETS + 1);
  localparam logic [PW-1:0] NIL  = PW'(ENTRIES);
  localparam logic [CW-1:0] BLST = CW'(BUCKETS - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LHASH, S_LBK, S_LBKD, S_WALK, S_WCMP, S_MISS, S_DEM, S_EVICT,
    S_EVRD, S_EVGOT, S_EHASH, S_RBK, S_RBKD, S_RWALK, S_RWGOT, S_RUNLINK,
    S_LRD, S_LGOT, S_REM, S_APP1, S_APP2, S_FILL, S_FILL2, S_FIN
  } state_t;

  typedef enum logic [1:0] {R_TOUCH, R_DEMOTE, R_EVICT, R_FILL} ret_t;

  // entry and bucket stores
  logic [DEVICE_BITS-1:0] tdev_m [ENTRIES];
  logic [PAGE_BITS-1:0]   tpg_m  [ENTRIES];
  logic                   act_m  [ENTRIES];
  logic [PW-1:0]          prev_m [ENTRIES];
  logic [PW-1:0]          next_m [ENTRIES];
  logic [PW-1:0]          link_m [ENTRIES];
  logic [PW-1:0]          bk_m   [BUCKETS];

  logic [DEVICE_BITS-1:0] tdev_rd;
  logic [PAGE_BITS-1:0]   tpg_rd;
  logic                   act_rd;
  logic [PW-1:0]          prev_rd, next_rd, link_rd, bk_rd;

  state_t state;
  ret_t   ret;
  logic [CW-1:0] clr;
  logic [DEVICE_BITS-1:0] dev_q;
  logic [PAGE_BITS-1:0]   pg_q;
  logic   wr_q;
  logic [BI-1:0] bkt, vb;
  logic [PW-1:0] cur, prv, steps, e, n, lp, ln, elink;
  logic   lact, a_new;
  logic [PW-1:0] ends [4];
  logic [PW-1:0] alloc, act_n, ina_n, dem;
  logic [31:0] hits, misses, evicts;
  logic   hit_r, fill_r, ev_r;
  logic [DEVICE_BITS-1:0] evd;
  logic [PAGE_BITS-1:0]   evp;

  // memory control
  logic [IW-1:0] ra, e_ix;
  logic [BI-1:0] bk_ra, bk_wa;
  logic [PW-1:0] bk_wd;
  logic bk_we, tag_we, act_we, link_we, prev_we, next_we;
  logic [IW-1:0] link_wa, prev_wa, next_wa;
  logic [PW-1:0] link_wd, prev_wd, next_wd;
  logic [1:0] rhi, rti, ahi, ati;

  // hash unit
  logic        hstart, hdone;
  logic [63:0] hx;
  logic [BI-1:0] hb;
  logic        acc_in;

  tlru_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hstart),
    .x     (hx),
    .done  (hdone),
    .bkt   (hb)
  );

  assign acc_in    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign e_ix      = e[IW-1:0];
  assign rhi       = lact ? ACT_HEAD : INA_HEAD;
  assign rti       = lact ? ACT_TAIL : INA_TAIL;
  assign ahi       = a_new ? ACT_HEAD : INA_HEAD;
  assign ati       = a_new ? ACT_TAIL : INA_TAIL;

  // hash starts on a new word and on the victim tag
  always_comb begin
    hstart = 1'b0;
    hx     = 64'(DEVICE_BITS'(req.device)) ^ 64'(PAGE_BITS'(req.page_number));
    if (state == S_IDLE) begin
      hstart = acc_in;
    end else if (state == S_EVGOT) begin
      hstart = 1'b1;
      hx     = 64'(tdev_rd) ^ 64'(tpg_rd);
    end
  end

  // read addresses and write strobes per step
  always_comb begin
    ra      = e_ix;
    bk_ra   = bkt;
    bk_we   = 1'b0;
    bk_wa   = bkt;
    bk_wd   = NIL;
    tag_we  = 1'b0;
    act_we  = 1'b0;
    link_we = 1'b0;
    link_wa = e_ix;
    link_wd = bk_rd;
    prev_we = 1'b0;
    prev_wa = e_ix;
    prev_wd = ends[ati];
    next_we = 1'b0;
    next_wa = e_ix;
    next_wd = NIL;
    case (state)
      S_CLR: begin
        bk_we = 1'b1;
        bk_wa = BI'(clr);
      end
      S_WALK, S_RWALK: ra = cur[IW-1:0];
      S_RBK: bk_ra = vb;
      S_RUNLINK: begin
        if (cur == e) begin
          if (prv == NIL) begin
            bk_we = 1'b1;
            bk_wa = vb;
            bk_wd = elink;
          end else begin
            link_we = 1'b1;
            link_wa = prv[IW-1:0];
            link_wd = elink;
          end
        end
      end
      S_REM: begin
        if (lp < NIL) begin
          next_we = 1'b1;
          next_wa = lp[IW-1:0];
          next_wd = ln;
        end
        if (ln < NIL) begin
          prev_we = 1'b1;
          prev_wa = ln[IW-1:0];
          prev_wd = lp;
        end
      end
      S_APP1: begin
        act_we  = 1'b1;
        prev_we = 1'b1;
        if (ends[ati] < NIL) begin
          next_we = 1'b1;
          next_wa = ends[ati][IW-1:0];
          next_wd = e;
        end
      end
      S_APP2: next_we = 1'b1;
      S_FILL: tag_we = 1'b1;
      S_FILL2: begin
        link_we = 1'b1;
        bk_we   = 1'b1;
        bk_wd   = e;
      end
      default: ra = e_ix;
    endcase
  end

  // store ports, read data registered
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tdev_m[e_ix] <= dev_q;
      tpg_m[e_ix]  <= pg_q;
    end
    if (act_we) begin
      act_m[e_ix] <= a_new;
    end
    if (link_we) begin
      link_m[link_wa] <= link_wd;
    end
    if (prev_we) begin
      prev_m[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_m[next_wa] <= next_wd;
    end
    if (bk_we) begin
      bk_m[bk_wa] <= bk_wd;
    end
    tdev_rd <= tdev_m[ra];
    tpg_rd  <= tpg_m[ra];
    act_rd  <= act_m[ra];
    prev_rd <= prev_m[ra];
    next_rd <= next_m[ra];
    link_rd <= link_m[ra];
    bk_rd   <= bk_m[bk_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      clr    <= '0;
      alloc  <= '0;
      act_n  <= '0;
      ina_n  <= '0;
      hits   <= '0;
      misses <= '0;
      evicts <= '0;
      for (int i = 0; i < 4; i++) begin
        ends[i] <= NIL;
      end
    end else begin
      case (state)
        S_CLR: begin
          clr <= clr + CW'(1);
          if (clr == BLST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_in) begin
            dev_q  <= DEVICE_BITS'(req.device);
            pg_q   <= PAGE_BITS'(req.page_number);
            wr_q   <= req.cmd;
            hit_r  <= 1'b0;
            fill_r <= 1'b0;
            ev_r   <= 1'b0;
            evd    <= '0;
            evp    <= '0;
            dem    <= '0;
            state  <= S_LHASH;
          end
        end
        S_LHASH: begin
          if (hdone) begin
            bkt   <= hb;
            state <= S_LBK;
          end
        end
        S_LBK: state <= S_LBKD;
        S_LBKD: begin
          cur   <= bk_rd;
          steps <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          state <= (cur < NIL && steps < NIL) ? S_WCMP : S_MISS;
        end
        S_WCMP: begin
          if (tdev_rd == dev_q && tpg_rd == pg_q) begin
            e     <= cur;
            hit_r <= 1'b1;
            if (!wr_q) begin
              hits <= hits + 32'd1;
            end
            a_new <= 1'b1;
            ret   <= R_TOUCH;
            state <= S_LRD;
          end else begin
            cur   <= link_rd;
            steps <= steps + PW'(1);
            state <= S_WALK;
          end
        end
        S_MISS: begin
          if (wr_q) begin
            state <= S_FIN;
          end else begin
            misses <= misses + 32'd1;
            if (alloc < NIL) begin
              e     <= alloc;
              alloc <= alloc + PW'(1);
              state <= S_FILL;
            end else if (ina_n < (act_n >> 1)) begin
              n     <= act_n >> 1;
              state <= S_DEM;
            end else begin
              state <= S_EVICT;
            end
          end
        end
        // move entries from the active head to the inactive tail
        S_DEM: begin
          if (n != '0 && ends[ACT_HEAD] < NIL) begin
            e     <= ends[ACT_HEAD];
            n     <= n - PW'(1);
            dem   <= dem + PW'(1);
            a_new <= 1'b0;
            ret   <= R_DEMOTE;
            state <= S_LRD;
          end else begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (ends[INA_HEAD] < NIL) begin
            e      <= ends[INA_HEAD];
            evicts <= evicts + 32'd1;
            ev_r   <= 1'b1;
            state  <= S_EVRD;
          end else begin
            state <= S_FIN;
          end
        end
        S_EVRD: state <= S_EVGOT;
        S_EVGOT: begin
          evd   <= tdev_rd;
          evp   <= tpg_rd;
          elink <= link_rd;
          state <= S_EHASH;
        end
        S_EHASH: begin
          if (hdone) begin
            vb    <= hb;
            state <= S_RBK;
          end
        end
        S_RBK: state <= S_RBKD;
        S_RBKD: begin
          cur   <= bk_rd;
          prv   <= NIL;
          steps <= '0;
          state <= S_RWALK;
        end
        // find the victim's predecessor on its chain
        S_RWALK: begin
          state <= (cur < NIL && cur != e && steps < NIL) ? S_RWGOT : S_RUNLINK;
        end
        S_RWGOT: begin
          prv   <= cur;
          cur   <= link_rd;
          steps <= steps + PW'(1);
          state <= S_RWALK;
        end
        S_RUNLINK: begin
          ret   <= R_EVICT;
          state <= S_LRD;
        end
        S_LRD: state <= S_LGOT;
        S_LGOT: begin
          lact <= act_rd;
          lp   <= prev_rd;
          ln   <= next_rd;
          if (ret == R_TOUCH && act_rd && ends[ACT_TAIL] == e) begin
            state <= S_FIN;
          end else begin
            state <= S_REM;
          end
        end
        // unlink from its recency list
        S_REM: begin
          if (lact) begin
            if (act_n != '0) begin
              act_n <= act_n - PW'(1);
            end
          end else if (ina_n != '0) begin
            ina_n <= ina_n - PW'(1);
          end
          if (!(lp < NIL) && ends[rhi] == e) begin
            ends[rhi] <= ln;
          end
          if (!(ln < NIL) && ends[rti] == e) begin
            ends[rti] <= lp;
          end
          state <= (ret == R_EVICT) ? S_FILL : S_APP1;
        end
        // link at the tail of the target list
        S_APP1: begin
          ends[ati] <= e;
          if (ends[ahi] >= NIL) begin
            ends[ahi] <= e;
          end
          if (a_new) begin
            act_n <= act_n + PW'(1);
          end else begin
            ina_n <= ina_n + PW'(1);
          end
          state <= S_APP2;
        end
        S_APP2: state <= (ret == R_DEMOTE) ? S_DEM : S_FIN;
        S_FILL: begin
          fill_r <= 1'b1;
          state  <= S_FILL2;
        end
        S_FILL2: begin
          a_new <= 1'b0;
          ret   <= R_FILL;
          state <= S_APP1;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word
  always_comb begin
    res_valid          = (state == S_FIN);
    res.hit            = hit_r;
    res.slot           = (hit_r || fill_r) ? 12'(e) : 12'd0;
    res.filled         = fill_r;
    res.evicted        = ev_r;
    res.evicted_device = 8'(evd);
    res.evicted_page   = 32'(evp);
    res.demoted        = 12'(dem);
    res.pages_used     = 13'(alloc);
    res.hit_count      = hits;
    res.miss_count     = misses;
    res.evict_count    = evicts;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/two_list_lru_page_cache_tags_top.sv =====
// result time grows with chain links walked, demoted entries and an eviction; a hit on the active tail skips the relink
// throughput: one word at a time, not ready until the result enters the output register
// each hash runs on one shared multiplier, with a reciprocal remainder when BUCKETS is not a power of two
// reset: synchronous; a clearing pass over all BUCKETS bucket heads follows before the first word
`timescale 1ns / 1ps
`default_nettype none

module two_list_lru_page_cache_tags_top #(
  parameter int ENTRIES     = 4096,
  parameter int BUCKETS     = 1024,
  parameter int DEVICE_BITS = 8,
  parameter int PAGE_BITS   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  tlru_req_if.sink  req,
  tlru_rsp_if.source rsp
);
  import tlru_pkg::*;

  tlru_res_t res, out_q;
  logic      res_valid, res_ready, out_v;

  tlru_engine #(
    .ENTRIES     (ENTRIES),
    .BUCKETS     (BUCKETS),
    .DEVICE_BITS (DEVICE_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_v || rsp.ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (res_ready) begin
      out_v <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.hit            = out_q.hit;
  assign rsp.slot           = out_q.slot;
  assign rsp.filled         = out_q.filled;
  assign rsp.evicted        = out_q.evicted;
  assign rsp.evicted_device = out_q.evicted_device;
  assign rsp.evicted_page   = out_q.evicted_page;
  assign rsp.demoted        = out_q.demoted;
  assign rsp.pages_used     = out_q.pages_used;
  assign rsp.hit_count      = out_q.hit_count;
  assign rsp.miss_count     = out_q.miss_count;
  assign rsp.evict_count    = out_q.evict_count;

endmodule

`default_nettype wire

// ===== hw/rtl/tlru_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlru_chk #(
  parameter int ENTRIES = 4096
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        hit,
  input wire logic        filled,
  input wire logic        evicted,
  input wire logic [12:0] pages_used
);

  // a held word stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // one word in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a hit never allocates
  a_hit_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && filled))
    else $error("hit and fill together");

  // eviction only as part of a fill
  a_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted |-> filled && !hit)
    else $error("eviction without fill");

  // pool use never exceeds the store
  a_pool: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pages_used <= 13'(ENTRIES))
    else $error("pool count out of range");

endmodule

bind two_list_lru_page_cache_tags_top tlru_chk #(.ENTRIES(ENTRIES)) u_tlru_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .hit        (rsp.hit),
  .filled     (rsp.filled),
  .evicted    (rsp.evicted),
  .pages_used (rsp.pages_used)
);

`default_nettype wire
